FILE: design/cbts_pkg.sv
// Package for the CAN bit timing solver: sequencer states, limits and the segment split.
`timescale 1ns / 1ps

package cbts_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_SCAN,
    ST_REM,
    ST_TEST,
    ST_EVAL,
    ST_FAIL
  } cbts_state_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] s1_code;
    logic [2:0] s2_code;
  } cbts_seg_t;

  localparam int unsigned CLK_W   = 30;
  localparam int unsigned RATE_W  = 24;
  localparam int unsigned PROD_W  = 15;
  localparam int unsigned SUM_W   = 5;
  localparam int unsigned CNT_W   = 5;

  localparam logic [CNT_W-1:0]  QUOT_LAST = 5'd29;   // one step per dividend bit
  localparam logic [CNT_W-1:0]  REM_LAST  = 5'd14;
  localparam logic [RATE_W-1:0] FAST_RATE = 24'd1000000;
  localparam logic [SUM_W-1:0]  SUM_FAST  = 5'd9;
  localparam logic [SUM_W-1:0]  SUM_SLOW  = 5'd16;
  localparam logic [SUM_W-1:0]  SUM_MIN   = 5'd2;
  localparam logic [CLK_W-1:0]  PROD_MAX  = 30'd17408; // 1024 prescale * 17 quanta
  localparam logic [PROD_W-1:0] PRESC_MAX = 15'd1024;
  localparam logic [CLK_W-1:0]  CLK_RESET = 30'd80000000;

  // Split the segment sum toward a 7/8 sample point; drop to truncation above 900 permille.
  function automatic cbts_seg_t seg_split(input logic [SUM_W-1:0] sum);
    cbts_seg_t        res;
    logic [7:0]       s1w;
    logic [15:0]      lhs;
    logic [15:0]      rhs;
    logic [SUM_W-1:0] s1;
    logic [SUM_W-1:0] s2;
    s1w = (8'(sum) * 8'd7 + 8'd3) >> 3;
    s1  = s1w[SUM_W-1:0];
    lhs = 16'd1000 * 16'(s1 + 5'd1);
    rhs = 16'd901 * 16'({1'b0, sum} + 6'd1);
    if (lhs >= rhs) begin
      s1w = (8'(sum) * 8'd7 - 8'd1) >> 3;
      s1  = s1w[SUM_W-1:0];
    end
    s2 = sum - s1;
    res.ok      = (s1 >= 5'd1) && (s1 <= 5'd16) && (s2 >= 5'd1) && (s2 <= 5'd8);
    res.s1_code = 4'(s1 - 5'd1);
    res.s2_code = 3'(s2 - 5'd1);
    return res;
  endfunction

endpackage

FILE: design/can_bit_timing_solver_core.sv
// CAN bit timing solver: one shared restoring divider stepped by a small sequencer.
//
//   channel  | ports                                              | handshake
//   ---------+----------------------------------------------------+---------------------------
//   input    | in_bitrate                                         | start && !busy
//   result   | out_ok, out_prescaler_code, out_seg1_code/seg2_code | out_valid, one-cycle strobe
//   config   | cfg_wr_data                                        | cfg_wr_en
//
// A word divides clock_hz by the bitrate, one divider step per dividend bit, then passes a
// scan state, then runs 15 remainder steps and a test for each segment sum tried (1 to 15
// sums), then an evaluation state. A zero bitrate or an out-of-range quotient ends early.
// rst_n is synchronous; it idles the sequencer and restores clock_hz to 80 MHz.
// The receiver cannot stall; busy stays high until the result strobe is issued.
`timescale 1ns / 1ps

module can_bit_timing_solver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] in_bitrate,
  input  logic        cfg_wr_en,
  input  logic [29:0] cfg_wr_data,
  output logic        out_valid,
  output logic        out_ok,
  output logic [9:0]  out_prescaler_code,
  output logic [3:0]  out_seg1_code,
  output logic [2:0]  out_seg2_code
);
  import cbts_pkg::*;

  cbts_state_t       state_r, state_nxt;
  logic [CLK_W-1:0]  clock_hz_r;
  logic [CLK_W-1:0]  q_r;
  logic [RATE_W-1:0] rem_r;
  logic [RATE_W-1:0] div_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  sum_r;
  logic [PROD_W-1:0] prod_r;
  logic [RATE_W-1:0] rem0_r;

  logic              out_valid_r;
  logic              out_ok_r;
  logic [9:0]        out_presc_r;
  logic [3:0]        out_seg1_r;
  logic [2:0]        out_seg2_r;

  // shared divider step
  logic [RATE_W:0]   r_sh;
  logic              ge;
  logic [RATE_W:0]   r_diff;
  logic [RATE_W-1:0] rem_step;
  logic [CLK_W-1:0]  q_step;

  logic              prod_bad;
  logic              last_step;
  logic              retry;
  logic [SUM_W-1:0]  sum_sel;
  logic [PROD_W-1:0] prod_sel;
  cbts_seg_t         seg;
  logic [PROD_W-1:0] presc;
  logic              eval_ok;

  logic              ld_quot;
  logic              step;
  logic              ld_rem;
  logic              save_prod;
  logic              rpt;
  logic              rpt_ok;

  assign r_sh     = {rem_r, q_r[CLK_W-1]};
  assign ge       = r_sh >= {1'b0, div_r};
  assign r_diff   = r_sh - {1'b0, div_r};
  assign rem_step = ge ? r_diff[RATE_W-1:0] : r_sh[RATE_W-1:0];
  assign q_step   = {q_r[CLK_W-2:0], ge};

  assign prod_bad  = (q_r == '0) || (q_r > PROD_MAX);
  assign last_step = (cnt_r == '0);
  assign retry     = (rem_r != '0) && (sum_r > SUM_MIN);
  assign sum_sel   = (state_r == ST_TEST) ? (sum_r - 5'd1) : sum_r;
  assign prod_sel  = (state_r == ST_TEST) ? prod_r : q_r[PROD_W-1:0];

  assign seg     = seg_split(sum_r);
  assign presc   = q_r[PROD_W-1:0];
  assign eval_ok = (presc != '0) && (presc <= PRESC_MAX) && seg.ok &&
                   (rem0_r < RATE_W'(prod_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) begin
        state_nxt = (in_bitrate == '0) ? ST_FAIL : ST_QUOT;
      end
      ST_QUOT: if (last_step) begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: state_nxt = prod_bad ? ST_FAIL : ST_REM;
      ST_REM: if (last_step) begin
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        priority if (rem_r == '0) state_nxt = ST_EVAL;
        else if (retry)           state_nxt = ST_REM;
        else                      state_nxt = ST_FAIL;
      end
      ST_EVAL: state_nxt = ST_IDLE;
      ST_FAIL: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer controls
  always_comb begin
    ld_quot   = 1'b0;
    step      = 1'b0;
    ld_rem    = 1'b0;
    save_prod = 1'b0;
    rpt       = 1'b0;
    rpt_ok    = 1'b0;
    unique case (state_r)
      ST_IDLE: ld_quot = start;
      ST_QUOT: step = 1'b1;
      ST_SCAN: begin
        save_prod = 1'b1;
        ld_rem    = !prod_bad;
      end
      ST_REM:  step = 1'b1;
      ST_TEST: ld_rem = retry;
      ST_EVAL: begin
        rpt    = 1'b1;
        rpt_ok = eval_ok;
      end
      ST_FAIL: rpt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clock_hz_r  <= CLK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= rpt;
      if (cfg_wr_en) begin
        clock_hz_r <= cfg_wr_data;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ld_quot) begin
      q_r   <= clock_hz_r;
      rem_r <= '0;
      div_r <= in_bitrate;
      cnt_r <= QUOT_LAST;
      sum_r <= (in_bitrate >= FAST_RATE) ? SUM_FAST : SUM_SLOW;
    end else if (step) begin
      q_r   <= q_step;
      rem_r <= rem_step;
      cnt_r <= cnt_r - 5'd1;
    end else if (ld_rem) begin
      // dividend sits in the top bits; 15 steps leave the quotient in the low bits
      q_r   <= {prod_sel, {(CLK_W-PROD_W){1'b0}}};
      rem_r <= '0;
      div_r <= RATE_W'({1'b0, sum_sel} + 6'd1);
      cnt_r <= REM_LAST;
      sum_r <= sum_sel;
    end
    if (save_prod) begin
      prod_r <= q_r[PROD_W-1:0];
      rem0_r <= rem_r;
    end
    if (rpt) begin
      out_ok_r    <= rpt_ok;
      out_presc_r <= rpt_ok ? 10'(presc - 15'd1) : '0;
      out_seg1_r  <= rpt_ok ? seg.s1_code : '0;
      out_seg2_r  <= rpt_ok ? seg.s2_code : '0;
    end
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_prescaler_code = out_presc_r;
  assign out_seg1_code      = out_seg1_r;
  assign out_seg2_code      = out_seg2_r;

endmodule
